[rtl/index_list_text_parser_assert.svh]
// Assertion macros used by the index list text parser back stage.
`ifndef INDEX_LIST_TEXT_PARSER_ASSERT_SVH
`define INDEX_LIST_TEXT_PARSER_ASSERT_SVH

// Checks in the same cycle: whenever cond holds, expr must hold too.
`define ILTP_ASSERT_IMPLY(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("iltp: same-cycle check failed");

// Next-edge check: whenever cond holds, expr must hold at the next edge.
`define ILTP_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("iltp: next-cycle check failed");

`endif

[rtl/iltp_pkg.sv]
// Shared types, character codes and the byte classifier of the index list text parser.
package iltp_pkg;

    localparam int VALUE_BITS         = 63;
    localparam int COUNT_OUT_BITS     = 32;
    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH        = 4;
    localparam int OUT_DEPTH          = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [2:0] {
        ST_VALUE   = 3'd0,
        ST_DONE    = 3'd1,
        ST_NEG     = 3'd2,
        ST_INVALID = 3'd3,
        ST_RANGE   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        MODE_SEP,
        MODE_WS,
        MODE_SIGNED,
        MODE_DIGITS,
        MODE_STOPPED
    } mode_t;

    typedef struct packed {
        logic       is_digit;
        logic       is_sep;
        logic       is_space;
        logic       is_vtff;
        logic       is_plus;
        logic       is_minus;
        logic       is_nul;
        logic [3:0] digit;
        logic       last;
    } token_t;

    typedef struct packed {
        status_t                   status;
        logic [VALUE_BITS-1:0]     value;
        logic [COUNT_OUT_BITS-1:0] count;
        logic                      run_end;
    } result_t;

    function automatic token_t classify(input logic [7:0] c, input logic last);
        token_t t;
        t.is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        t.is_sep   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA) ||
                     (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_LF) ||
                     (c == CH_CR);
        t.is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                     (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
        t.is_vtff  = (c == CH_VT) || (c == CH_FF);
        t.is_plus  = (c == CH_PLUS);
        t.is_minus = (c == CH_MINUS);
        t.is_nul   = (c == CH_NUL);
        // The low nibble of an ASCII digit is its value.
        t.digit    = c[3:0];
        t.last     = last;
        return t;
    endfunction

endpackage

[rtl/iltp_front.sv]
// Front stage: accepts text bytes, classifies them and hands them to the queue.
module iltp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      text_byte,
    input  logic            final_byte,
    input  logic            q_full,
    output logic            q_push,
    output iltp_pkg::token_t q_token
);
    import iltp_pkg::*;

    logic   tok_valid_reg;
    logic   tok_valid_next;
    token_t tok_reg;
    logic   accept;

    assign in_stall = tok_valid_reg && q_full;
    assign q_push   = tok_valid_reg && !q_full;
    assign q_token  = tok_reg;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        tok_valid_next = tok_valid_reg;
        if (accept)
        begin
            tok_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            tok_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_reg <= classify(text_byte, final_byte);
        end
    end

endmodule

[rtl/iltp_queue.sv]
// Short queue of classified words between the front and back stages.
module iltp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  iltp_pkg::token_t push_token,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output iltp_pkg::token_t head_token
);
    import iltp_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    token_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]   fill_reg, fill_next;
    logic                push_ok;
    logic                pop_ok;

    assign full       = (fill_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign empty      = (fill_reg == '0);
    assign head_token = entry_reg[rd_ptr_reg];
    assign push_ok    = push && !full;
    assign pop_ok     = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

[rtl/iltp_back.sv]
// Back stage: runs the token scanner on queued words and buffers the results.
`include "index_list_text_parser_assert.svh"

module iltp_back #(
    parameter int COUNT_BITS = iltp_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  iltp_pkg::token_t                    q_head,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          status,
    output logic [iltp_pkg::VALUE_BITS-1:0]     index_value,
    output logic [iltp_pkg::COUNT_OUT_BITS-1:0] value_count,
    output logic                                run_end
);
    import iltp_pkg::*;

    localparam int RING_PTR_BITS = $clog2(OUT_DEPTH);

    typedef struct packed {
        mode_t                 mode;
        logic [VALUE_BITS-1:0] acc;
        logic                  ovf;
        logic                  minus;
        logic [COUNT_BITS-1:0] count;
        logic                  halted;
    } scan_t;

    typedef struct packed {
        scan_t          s;
        logic [1:0]     n;
        result_t [1:0]  r;
    } feed_t;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam scan_t SCAN_RESET = '{
        mode: MODE_SEP, acc: '0, ovf: 1'b0, minus: 1'b0, count: '0, halted: 1'b0
    };

    function automatic logic [COUNT_OUT_BITS-1:0] count_out(input logic [COUNT_BITS-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return w[COUNT_OUT_BITS-1:0];
    endfunction

    function automatic result_t make_result(input status_t st,
                                            input logic [VALUE_BITS-1:0] v,
                                            input logic [COUNT_BITS-1:0] c);
        result_t r;
        r.status  = st;
        r.value   = v;
        r.count   = count_out(c);
        r.run_end = 1'b0;
        return r;
    endfunction

    // One scanner step on one character, with at most two results.
    function automatic feed_t feed(input scan_t s, input token_t t);
        feed_t                 f;
        logic                  between;
        logic [VALUE_BITS+3:0] prod;
        f       = '0;
        f.s     = s;
        between = 1'b0;
        // Ten times the accumulator plus the new digit; any bit from 63 up is an overflow.
        prod = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + (VALUE_BITS+4)'(t.digit);
        if (!s.halted)
        begin
            unique case (s.mode)
                MODE_DIGITS:
                begin
                    if (t.is_digit)
                    begin
                        if (s.ovf || (prod[VALUE_BITS+3:VALUE_BITS] != 4'b0))
                        begin
                            f.s.ovf = 1'b1;
                        end
                        else
                        begin
                            f.s.acc = prod[VALUE_BITS-1:0];
                        end
                    end
                    else if (s.ovf || (s.minus && (s.acc != '0)))
                    begin
                        f.r[0]   = make_result(ST_RANGE, '0, s.count);
                        f.n      = 2'd1;
                        f.s.halted = 1'b1;
                    end
                    else
                    begin
                        if (s.count != COUNT_MAX)
                        begin
                            f.s.count = s.count + 1'b1;
                        end
                        f.r[0]   = make_result(ST_VALUE, s.acc, f.s.count);
                        f.n      = 2'd1;
                        f.s.mode = MODE_SEP;
                        // The terminating character is looked at again as a token start.
                        between  = 1'b1;
                    end
                end
                MODE_SIGNED:
                begin
                    if (t.is_digit)
                    begin
                        f.s.acc  = VALUE_BITS'(t.digit);
                        f.s.ovf  = 1'b0;
                        f.s.mode = MODE_DIGITS;
                    end
                    else
                    begin
                        f.r[0]     = make_result(ST_INVALID, '0, s.count);
                        f.n        = 2'd1;
                        f.s.halted = 1'b1;
                    end
                end
                MODE_WS:
                begin
                    priority if (t.is_space)
                    begin
                        f.s.mode = MODE_WS;
                    end
                    else if (t.is_plus)
                    begin
                        f.s.mode = MODE_SIGNED;
                    end
                    else if (t.is_minus)
                    begin
                        f.s.minus = 1'b1;
                        f.s.mode  = MODE_SIGNED;
                    end
                    else if (t.is_digit)
                    begin
                        f.s.acc  = VALUE_BITS'(t.digit);
                        f.s.ovf  = 1'b0;
                        f.s.mode = MODE_DIGITS;
                    end
                    else
                    begin
                        f.r[0]     = make_result(ST_INVALID, '0, s.count);
                        f.n        = 2'd1;
                        f.s.halted = 1'b1;
                    end
                end
                MODE_SEP:
                begin
                    between = 1'b1;
                end
                MODE_STOPPED:
                begin
                    f.s.mode = MODE_STOPPED;
                end
            endcase

            if (between)
            begin
                priority if (t.is_nul)
                begin
                    f.s.mode = MODE_STOPPED;
                end
                else if (t.is_sep)
                begin
                    f.s.mode = MODE_SEP;
                end
                else
                begin
                    f.s.minus = 1'b0;
                    priority if (t.is_minus)
                    begin
                        f.r[f.n[0]] = make_result(ST_NEG, '0, f.s.count);
                        f.n         = f.n + 2'd1;
                        f.s.halted  = 1'b1;
                    end
                    else if (t.is_vtff)
                    begin
                        f.s.mode = MODE_WS;
                    end
                    else if (t.is_plus)
                    begin
                        f.s.mode = MODE_SIGNED;
                    end
                    else if (t.is_digit)
                    begin
                        f.s.acc  = VALUE_BITS'(t.digit);
                        f.s.ovf  = 1'b0;
                        f.s.mode = MODE_DIGITS;
                    end
                    else
                    begin
                        f.r[f.n[0]] = make_result(ST_INVALID, '0, f.s.count);
                        f.n         = f.n + 2'd1;
                        f.s.halted  = 1'b1;
                    end
                end
            end
        end
        return f;
    endfunction

    function automatic logic [RING_PTR_BITS-1:0] ring_inc(input logic [RING_PTR_BITS-1:0] p,
                                                          input logic [1:0] k);
        logic [RING_PTR_BITS+1:0] s;
        s = (RING_PTR_BITS+2)'(p) + (RING_PTR_BITS+2)'(k);
        if (s >= (RING_PTR_BITS+2)'(OUT_DEPTH))
        begin
            s = s - (RING_PTR_BITS+2)'(OUT_DEPTH);
        end
        return s[RING_PTR_BITS-1:0];
    endfunction

    scan_t                    state_reg, state_next;
    feed_t                    f_byte, f_end;
    result_t [1:0]            push_res;
    logic [1:0]               push_n;
    logic [1:0]               step_n;
    result_t                  ring_reg [OUT_DEPTH];
    logic [RING_PTR_BITS-1:0] ring_wr_reg, ring_wr_next;
    logic [RING_PTR_BITS-1:0] ring_wr_second;
    logic [RING_PTR_BITS-1:0] ring_rd_reg, ring_rd_next;
    logic [RING_PTR_BITS:0]   ring_cnt_reg, ring_cnt_next;
    logic                     out_pop;
    result_t                  ring_head;
    logic                     run_cleared;

    // A word is taken only when the ring has room for both of its possible results.
    assign q_pop = !q_empty && (ring_cnt_reg <= (RING_PTR_BITS+1)'(OUT_DEPTH - 2));

    always_comb
    begin
        f_byte     = feed(state_reg, q_head);
        f_end      = feed(f_byte.s, classify(CH_NUL, 1'b0));
        push_res   = '0;
        step_n     = 2'd0;
        state_next = state_reg;
        for (int i = 0; i < 2; i++)
        begin
            if ((2'(i) < f_byte.n) && (step_n != 2'd2))
            begin
                push_res[step_n[0]] = f_byte.r[i];
                step_n              = step_n + 2'd1;
            end
        end
        if (q_head.last)
        begin
            for (int i = 0; i < 2; i++)
            begin
                if ((2'(i) < f_end.n) && (step_n != 2'd2))
                begin
                    push_res[step_n[0]] = f_end.r[i];
                    step_n              = step_n + 2'd1;
                end
            end
            if (!f_end.s.halted && (step_n != 2'd2))
            begin
                push_res[step_n[0]] = make_result(ST_DONE, '0, f_end.s.count);
                step_n              = step_n + 2'd1;
            end
        end
        if (step_n == 2'd2)
        begin
            push_res[1].run_end = 1'b1;
        end
        else if (step_n == 2'd1)
        begin
            push_res[0].run_end = 1'b1;
        end
        if (q_pop)
        begin
            state_next = q_head.last ? SCAN_RESET : f_byte.s;
        end
        push_n = q_pop ? step_n : 2'd0;
    end

    assign ring_head   = ring_reg[ring_rd_reg];
    assign out_valid   = (ring_cnt_reg != '0);
    assign out_pop     = out_valid && !out_stall;
    assign status      = ring_head.status;
    assign index_value = ring_head.value;
    assign value_count = ring_head.count;
    assign run_end     = ring_head.run_end;

    always_comb
    begin
        ring_wr_second = ring_inc(ring_wr_reg, 2'd1);
        ring_wr_next   = ring_inc(ring_wr_reg, push_n);
        ring_rd_next   = out_pop ? ring_inc(ring_rd_reg, 2'd1) : ring_rd_reg;
        ring_cnt_next  = ring_cnt_reg + (RING_PTR_BITS+1)'(push_n)
                         - (RING_PTR_BITS+1)'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SCAN_RESET;
            ring_wr_reg  <= '0;
            ring_rd_reg  <= '0;
            ring_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ring_wr_reg  <= ring_wr_next;
            ring_rd_reg  <= ring_rd_next;
            ring_cnt_reg <= ring_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            ring_reg[ring_wr_reg] <= push_res[0];
        end
        if (push_n == 2'd2)
        begin
            ring_reg[ring_wr_second] <= push_res[1];
        end
    end

    assign run_cleared = (state_reg.mode == MODE_SEP) && !state_reg.halted &&
                         (state_reg.count == '0);

    `ILTP_ASSERT_IMPLY(a_ring_room, q_pop, ring_cnt_reg <= (RING_PTR_BITS+1)'(OUT_DEPTH - 2))
    `ILTP_ASSERT_IMPLY(a_ring_bound, 1'b1, ring_cnt_reg <= (RING_PTR_BITS+1)'(OUT_DEPTH))
    `ILTP_ASSERT_IMPLY(a_halted_quiet, q_pop && state_reg.halted && !q_head.last, push_n == 2'd0)
    `ILTP_ASSERT_NEXT(a_run_restart, q_pop && q_head.last, run_cleared)

endmodule

[rtl/index_list_text_parser.sv]
// Bytes pass through the front register, the queue and the result ring to the output.
// Throughput: one byte per cycle while each byte gives at most one result and out_stall is
// low; the single output port takes one word per cycle, so two-result bytes fill the ring.
// The back stage holds a new byte until its four-entry result ring has room for two words.
// Reset (rst_n low, asynchronous) clears the scanner, the queue and the result ring at once;
// the block takes bytes as soon as reset is released, with no clearing pass.
module index_list_text_parser #(
    parameter int COUNT_BITS = iltp_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          text_byte,
    input  logic                                final_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          status,
    output logic [iltp_pkg::VALUE_BITS-1:0]     index_value,
    output logic [iltp_pkg::COUNT_OUT_BITS-1:0] value_count,
    output logic                                run_end
);
    import iltp_pkg::*;

    logic   q_full;
    logic   q_push;
    token_t q_token;
    logic   q_empty;
    logic   q_pop;
    token_t q_head;

    iltp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_token    (q_token)
    );

    iltp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_token (q_token),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_token (q_head)
    );

    iltp_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .index_value (index_value),
        .value_count (value_count),
        .run_end     (run_end)
    );

endmodule
